@@ src/lvma_pkg.sv @@
// Package for the label vector medoid assignment block.
// Holds the sizing constants, command and register codes, the scan state type
// and the control/status structs shared between the top level and the scan engine.
package lvma_pkg;

    // Table and label geometry
    localparam int MEDOIDS     = 256;
    localparam int DIMENSIONS  = 4;
    localparam int LABEL_BITS  = 16;
    localparam int LANE_STRIDE = 16;
    localparam int VEC_W       = 64;

    // Derived widths
    localparam int IDX_W   = (MEDOIDS > 1) ? $clog2(MEDOIDS) : 1;
    localparam int COUNT_W = $clog2(MEDOIDS + 1);
    localparam int LIM_W   = (COUNT_W > 9) ? COUNT_W : 9;
    localparam int LD_W    = (COUNT_W > 8) ? COUNT_W : 8;

    // Field and register widths
    localparam int CLUSTER_W   = 8;
    localparam int MATCH_W     = 3;
    localparam int MED_CFG_W   = 9;
    localparam int DIM_CFG_W   = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;

    // Commands carried by an input transaction
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MEDOIDS_IN_USE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIMENSIONS_IN_USE = 1'b1;

    // Scan engine states
    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_RUN,
        SCAN_DRAIN,
        SCAN_DONE
    } scan_state_t;

    // Start request from the top level, limits already saturated
    typedef struct packed {
        logic                 start;
        logic [COUNT_W-1:0]   m_lim;
        logic [DIM_CFG_W-1:0] d_lim;
    } scan_cmd_t;

    // Status back from the scan engine
    typedef struct packed {
        logic               idle;
        logic               done;
        logic [IDX_W-1:0]   best_idx;
        logic [MATCH_W-1:0] best_cnt;
    } scan_stat_t;

endpackage

@@ src/lvma_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
module lvma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/lvma_scan.sv @@
// Scan engine: sweeps the medoid table one entry per cycle, counts matching
// label lanes and keeps the first entry with the highest count.
// Depends on lvma_pkg; drives the read port of the medoid RAM.
module lvma_scan import lvma_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  scan_cmd_t         cmd,
    input  logic [VEC_W-1:0]  vector,
    input  logic              ack,
    output scan_stat_t        stat,
    output logic              rd_en,
    output logic [IDX_W-1:0]  rd_addr,
    input  logic [VEC_W-1:0]  rd_data
);

    scan_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic [COUNT_W-1:0]   lim_reg, lim_next;
    logic [DIM_CFG_W-1:0] dlim_reg, dlim_next;
    logic [VEC_W-1:0]     vec_reg, vec_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]     pipe_idx_reg, pipe_idx_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [MATCH_W-1:0]   best_cnt_reg, best_cnt_next;

    logic                 addr_last;
    logic                 load_cfg;
    logic                 advance;
    logic [MATCH_W-1:0]   cnt;

    // Last entry in use reached by the read address
    assign addr_last = ((COUNT_W'(addr_reg) + COUNT_W'(1)) == lim_reg);

    // Lane-wise label compare against the entry read last cycle
    always_comb begin
        cnt = '0;
        for (int d = 0; d < DIMENSIONS; d++) begin
            if ((DIM_CFG_W'(d) < dlim_reg) &&
                (rd_data[d*LANE_STRIDE +: LABEL_BITS] ==
                 vec_reg[d*LANE_STRIDE +: LABEL_BITS])) begin
                cnt = cnt + MATCH_W'(1);
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SCAN_IDLE:  if (cmd.start) state_next = SCAN_RUN;
            SCAN_RUN:   if (addr_last) state_next = SCAN_DRAIN;
            SCAN_DRAIN: state_next = SCAN_DONE;
            SCAN_DONE:  if (ack) state_next = SCAN_IDLE;
            default:    state_next = SCAN_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        load_cfg      = 1'b0;
        advance       = 1'b0;
        stat.idle     = 1'b0;
        stat.done     = 1'b0;
        stat.best_idx = best_idx_reg;
        stat.best_cnt = best_cnt_reg;
        unique case (state_reg)
            SCAN_IDLE: begin
                stat.idle = 1'b1;
                load_cfg  = cmd.start;
            end
            SCAN_RUN:   advance   = 1'b1;
            SCAN_DRAIN: advance   = 1'b0;
            SCAN_DONE:  stat.done = 1'b1;
            default:    advance   = 1'b0;
        endcase
    end

    assign rd_en         = advance;
    assign rd_addr       = addr_reg;

    // Datapath next values
    always_comb begin
        addr_next     = addr_reg;
        lim_next      = lim_reg;
        dlim_next     = dlim_reg;
        vec_next      = vec_reg;
        best_idx_next = best_idx_reg;
        best_cnt_next = best_cnt_reg;
        rd_valid_next = advance;
        pipe_idx_next = addr_reg;
        if (load_cfg) begin
            addr_next = '0;
            lim_next  = cmd.m_lim;
            dlim_next = cmd.d_lim;
            vec_next  = vector;
        end else if (advance) begin
            addr_next = addr_reg + IDX_W'(1);
        end
        // First entry seeds the best; later ones replace it only on a strictly higher count
        if (rd_valid_reg) begin
            if ((pipe_idx_reg == '0) || (cnt > best_cnt_reg)) begin
                best_idx_next = pipe_idx_reg;
                best_cnt_next = cnt;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= SCAN_IDLE;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        lim_reg      <= lim_next;
        dlim_reg     <= dlim_next;
        vec_reg      <= vec_next;
        pipe_idx_reg <= pipe_idx_next;
        best_idx_reg <= best_idx_next;
        best_cnt_reg <= best_cnt_next;
    end

endmodule

@@ src/label_vector_medoid_assign.sv @@
// Label vector medoid assignment: nearest medoid by lane-wise label matches.
// Top level: configuration registers, input/output handshakes, medoid RAM.
// Depends on lvma_pkg, lvma_ram and lvma_scan.
//
// Usage: the input channel (s_*) takes load and classify transactions. A load
// writes s_label_vector into medoid entry s_medoid_index and
// returns nothing. A classify compares s_label_vector with medoid entries
// 0 .. medoids_in_use-1 over the first dimensions_in_use lanes and returns one
// transaction on the result channel (m_*): the lowest index with the highest
// match count, and that count.
// Timing: the medoid RAM gives one entry per cycle while a scan runs; the scan
// then drains the last read and holds its result until the output register
// takes it. s_ready is low while a scan runs and until that hand-over.
// Stalls: the output register holds a result while m_ready is low; loads and a
// new classify are still taken meanwhile, and a finished scan waits for the
// register to free before the block takes further transactions.
// Reset: medoids_in_use returns to 256 and dimensions_in_use to 4; medoid
// entries are undefined until loaded. Configuration is written via cfg_wr_en,
// cfg_index and cfg_data; the user must write it only while the block is idle, as the block does not enforce this.
module label_vector_medoid_assign import lvma_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    input  logic [7:0]             s_medoid_index,
    input  logic [VEC_W-1:0]       s_label_vector,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [CLUSTER_W-1:0]   m_cluster_index,
    output logic [MATCH_W-1:0]     m_match_count
);

    logic [MED_CFG_W-1:0] med_cfg_reg, med_cfg_next;
    logic [DIM_CFG_W-1:0] dim_cfg_reg, dim_cfg_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CLUSTER_W-1:0] cluster_reg, cluster_next;
    logic [MATCH_W-1:0]   count_reg, count_next;

    logic                 s_accept;
    logic                 ld_in_range;
    logic [LD_W-1:0]      ld_idx;
    logic [LIM_W-1:0]     m_lim_ext;
    logic [LIM_W-1:0]     m_lim_sat;
    logic [DIM_CFG_W-1:0] d_lim_sat;
    logic [LD_W-1:0]      best_ext;
    logic                 ack;

    scan_cmd_t            cmd;
    scan_stat_t           stat;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [VEC_W-1:0]     rd_data;

    // Input handshake
    assign s_ready  = stat.idle;
    assign s_accept = s_valid & s_ready;

    // Load address check
    assign ld_idx      = LD_W'(s_medoid_index);
    assign ld_in_range = (ld_idx < LD_W'(MEDOIDS));

    // Saturate the limits to their legal ranges
    always_comb begin
        m_lim_ext = LIM_W'(med_cfg_reg);
        priority if (m_lim_ext == '0) begin
            m_lim_sat = LIM_W'(1);
        end else if (m_lim_ext > LIM_W'(MEDOIDS)) begin
            m_lim_sat = LIM_W'(MEDOIDS);
        end else begin
            m_lim_sat = m_lim_ext;
        end
        priority if (dim_cfg_reg == '0) begin
            d_lim_sat = DIM_CFG_W'(1);
        end else if (dim_cfg_reg > DIM_CFG_W'(DIMENSIONS)) begin
            d_lim_sat = DIM_CFG_W'(DIMENSIONS);
        end else begin
            d_lim_sat = dim_cfg_reg;
        end
    end

    assign cmd.start = s_accept && (s_command == CMD_CLASSIFY);
    assign cmd.m_lim = m_lim_sat[COUNT_W-1:0];
    assign cmd.d_lim = d_lim_sat;

    // Medoid table
    lvma_ram #(
        .WIDTH (VEC_W),
        .DEPTH (MEDOIDS)
    ) u_medoid_ram (
        .aclk    (aclk),
        .wr_en   (s_accept && (s_command == CMD_LOAD) && ld_in_range),
        .wr_addr (ld_idx[IDX_W-1:0]),
        .wr_data (s_label_vector),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Search engine
    lvma_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .vector  (s_label_vector),
        .ack     (ack),
        .stat    (stat),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Configuration writes
    always_comb begin
        med_cfg_next = med_cfg_reg;
        dim_cfg_next = dim_cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MEDOIDS_IN_USE:    med_cfg_next = cfg_data[MED_CFG_W-1:0];
                CFG_DIMENSIONS_IN_USE: dim_cfg_next = cfg_data[DIM_CFG_W-1:0];
                default:               med_cfg_next = med_cfg_reg;
            endcase
        end
    end

    // Output register: takes a finished scan when empty or being drained
    assign ack      = stat.done && (!m_valid_reg || m_ready);
    assign best_ext = LD_W'(stat.best_idx);

    always_comb begin
        m_valid_next = m_valid_reg;
        cluster_next = cluster_reg;
        count_next   = count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ack) begin
            m_valid_next = 1'b1;
            cluster_next = best_ext[CLUSTER_W-1:0];
            count_next   = stat.best_cnt;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            med_cfg_reg <= MED_CFG_W'(256);
            dim_cfg_reg <= DIM_CFG_W'(4);
            m_valid_reg <= 1'b0;
        end else begin
            med_cfg_reg <= med_cfg_next;
            dim_cfg_reg <= dim_cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        cluster_reg <= cluster_next;
        count_reg   <= count_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_cluster_index = cluster_reg;
    assign m_match_count   = count_reg;

endmodule
